// File: rtl/tbsr_pkg.sv
// shared types and fixed widths for the tcp byte stream reassembler
// no dependencies; used by the top level tcp_byte_stream_reassembler
package tbsr_pkg;

    localparam int INDEX_W = 64;
    localparam int BYTE_W  = 8;
    localparam int COUNT_W = 7;

    // one input transfer: a stream byte or an end marker
    typedef struct packed {
        logic [INDEX_W-1:0] stream_index;
        logic [BYTE_W-1:0]  data_byte;
        logic               byte_present;
        logic               ends_stream;
        logic [COUNT_W-1:0] free_space;
    } item_t;

    // one result transfer: a released byte or a status word
    typedef struct packed {
        logic [BYTE_W-1:0]  out_byte;
        logic               out_valid;
        logic               run_last;
        logic               stream_closed;
        logic [COUNT_W-1:0] pending_count;
    } result_t;

endpackage

// File: rtl/tcp_byte_stream_reassembler.sv
// tcp byte stream reassembler top level: window store, release sequencer, result register
// depends on tbsr_pkg

// Takes one stream byte per input transfer with its absolute index and the downstream free
// space, keeps out-of-order bytes in a window of CAPACITY slots and releases the contiguous
// run at the next expected index, in order, one result per byte, the last flagged run_last.
// An item that releases nothing gives one status result with out_valid low. Every result
// carries the closed flag and held byte count as they stand after the whole item.
// An item is taken in the idle state; the accept state places the byte and records the end
// index, or, once the stream has closed, goes straight to a status result. A walk over the
// valid bits then steps one slot a cycle through a single index incrementer and stops on the
// first empty slot or after CAPACITY slots, and the close compare follows. The release then
// runs through the one registered read port of the byte store at one byte a cycle while the
// result side is ready, or is a single status result. The input is not ready while an item
// is in work; the result register lets the next item be taken while the last result still
// waits.
module tcp_byte_stream_reassembler #(
    parameter int CAPACITY = 64
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             item_valid,
    output logic             item_ready,
    input  tbsr_pkg::item_t  item,
    output logic             result_valid,
    input  logic             result_ready,
    output tbsr_pkg::result_t result
);

    localparam int SLOT_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CNT_W  = $clog2(CAPACITY + 1);

    typedef enum logic [5:0] {
        S_IDLE   = 6'b000001,
        S_ACCEPT = 6'b000010,
        S_SCAN   = 6'b000100,
        S_CHECK  = 6'b001000,
        S_EMIT   = 6'b010000,
        S_STATUS = 6'b100000
    } state_t;

    state_t state_reg, state_next;

    tbsr_pkg::item_t item_reg;

    logic [CAPACITY-1:0] valid_reg, valid_next;
    logic [tbsr_pkg::INDEX_W-1:0] next_index_reg, next_index_next;
    logic [tbsr_pkg::INDEX_W-1:0] end_index_reg, end_index_next;
    logic end_known_reg, end_known_next;
    logic closed_reg, closed_next;
    logic [tbsr_pkg::COUNT_W-1:0] held_reg, held_next;
    logic [SLOT_W-1:0] next_slot_reg, next_slot_next;
    logic [SLOT_W-1:0] emit_ptr_reg, emit_ptr_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic [CNT_W-1:0] rem_reg, rem_next;

    logic rd_valid_reg, rd_valid_next;
    logic rd_last_reg, rd_last_next;
    logic [tbsr_pkg::BYTE_W-1:0] rd_data_reg;

    logic result_valid_reg, result_valid_next;
    tbsr_pkg::result_t result_reg, result_next;

    logic [tbsr_pkg::BYTE_W-1:0] window_mem [CAPACITY];

    // acceptance test and slot placement
    logic [tbsr_pkg::INDEX_W:0] diff;
    logic [tbsr_pkg::INDEX_W-1:0] offset;
    logic [tbsr_pkg::COUNT_W-1:0] win;
    logic in_window;
    logic [7:0] slot_sum;
    logic [7:0] slot_adj;
    logic [SLOT_W-1:0] wr_slot;
    logic wr_en;
    logic rd_en;
    logic out_free;
    logic move;

    assign diff   = {1'b0, item_reg.stream_index} - {1'b0, next_index_reg};
    assign offset = diff[tbsr_pkg::INDEX_W-1:0];
    assign win    = (item_reg.free_space > tbsr_pkg::COUNT_W'(CAPACITY))
                    ? tbsr_pkg::COUNT_W'(CAPACITY) : item_reg.free_space;
    assign in_window = item_reg.byte_present && !diff[tbsr_pkg::INDEX_W]
                       && (offset[tbsr_pkg::INDEX_W-1:tbsr_pkg::COUNT_W] == '0)
                       && (offset[tbsr_pkg::COUNT_W-1:0] < win);
    assign slot_sum = 8'(next_slot_reg) + 8'(offset[tbsr_pkg::COUNT_W-1:0]);
    assign slot_adj = (slot_sum >= 8'(CAPACITY)) ? (slot_sum - 8'(CAPACITY)) : slot_sum;
    assign wr_slot  = slot_adj[SLOT_W-1:0];
    assign wr_en    = (state_reg == S_ACCEPT) && !closed_reg && in_window;

    // release pipeline handshakes
    assign out_free = !result_valid_reg || result_ready;
    assign move     = rd_valid_reg && out_free;
    assign rd_en    = (state_reg == S_EMIT) && (rem_reg != '0) && (!rd_valid_reg || move);

    assign item_ready   = (state_reg == S_IDLE);
    assign result_valid = result_valid_reg;
    assign result       = result_reg;

    // sequencer
    always_comb
    begin
        state_next        = state_reg;
        valid_next        = valid_reg;
        next_index_next   = next_index_reg;
        end_index_next    = end_index_reg;
        end_known_next    = end_known_reg;
        closed_next       = closed_reg;
        held_next         = held_reg;
        next_slot_next    = next_slot_reg;
        emit_ptr_next     = emit_ptr_reg;
        cnt_next          = cnt_reg;
        rem_next          = rem_reg;
        rd_valid_next     = rd_valid_reg;
        rd_last_next      = rd_last_reg;
        result_valid_next = result_valid_reg && !result_ready;
        result_next       = result_reg;

        unique case (state_reg)
            S_IDLE:
            begin
                if (item_valid)
                begin
                    state_next = S_ACCEPT;
                end
            end
            S_ACCEPT:
            begin
                cnt_next      = '0;
                emit_ptr_next = next_slot_reg;
                if (closed_reg)
                begin
                    state_next = S_STATUS;
                end
                else
                begin
                    if (item_reg.ends_stream)
                    begin
                        end_known_next = 1'b1;
                        end_index_next = item_reg.byte_present
                                         ? item_reg.stream_index + 1'b1
                                         : item_reg.stream_index;
                    end
                    if (in_window)
                    begin
                        valid_next[wr_slot] = 1'b1;
                        if (!valid_reg[wr_slot])
                        begin
                            held_next = held_reg + 1'b1;
                        end
                    end
                    state_next = S_SCAN;
                end
            end
            S_SCAN:
            begin
                if (valid_reg[next_slot_reg] && (cnt_reg < CNT_W'(CAPACITY)))
                begin
                    valid_next[next_slot_reg] = 1'b0;
                    cnt_next        = cnt_reg + 1'b1;
                    next_index_next = next_index_reg + 1'b1;
                    held_next       = held_reg - 1'b1;
                    next_slot_next  = (next_slot_reg == SLOT_W'(CAPACITY - 1))
                                      ? '0 : next_slot_reg + 1'b1;
                end
                else
                begin
                    state_next = S_CHECK;
                end
            end
            S_CHECK:
            begin
                if (end_known_reg && (next_index_reg >= end_index_reg))
                begin
                    closed_next = 1'b1;
                end
                rem_next   = cnt_reg;
                state_next = (cnt_reg == '0) ? S_STATUS : S_EMIT;
            end
            S_EMIT:
            begin
                if (move)
                begin
                    result_valid_next          = 1'b1;
                    result_next.out_byte       = rd_data_reg;
                    result_next.out_valid      = 1'b1;
                    result_next.run_last       = rd_last_reg;
                    result_next.stream_closed  = closed_reg;
                    result_next.pending_count  = held_reg;
                    rd_valid_next              = 1'b0;
                end
                if (rd_en)
                begin
                    rd_valid_next = 1'b1;
                    rd_last_next  = (rem_reg == CNT_W'(1));
                    rem_next      = rem_reg - 1'b1;
                    emit_ptr_next = (emit_ptr_reg == SLOT_W'(CAPACITY - 1))
                                    ? '0 : emit_ptr_reg + 1'b1;
                end
                if ((rem_reg == '0) && !rd_valid_reg)
                begin
                    state_next = S_IDLE;
                end
            end
            S_STATUS:
            begin
                if (out_free)
                begin
                    result_valid_next         = 1'b1;
                    result_next.out_byte      = '0;
                    result_next.out_valid     = 1'b0;
                    result_next.run_last      = 1'b1;
                    result_next.stream_closed = closed_reg;
                    result_next.pending_count = held_reg;
                    state_next                = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= S_IDLE;
            valid_reg        <= '0;
            next_index_reg   <= '0;
            end_index_reg    <= '0;
            end_known_reg    <= 1'b0;
            closed_reg       <= 1'b0;
            held_reg         <= '0;
            next_slot_reg    <= '0;
            emit_ptr_reg     <= '0;
            cnt_reg          <= '0;
            rem_reg          <= '0;
            rd_valid_reg     <= 1'b0;
            rd_last_reg      <= 1'b0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg        <= state_next;
            valid_reg        <= valid_next;
            next_index_reg   <= next_index_next;
            end_index_reg    <= end_index_next;
            end_known_reg    <= end_known_next;
            closed_reg       <= closed_next;
            held_reg         <= held_next;
            next_slot_reg    <= next_slot_next;
            emit_ptr_reg     <= emit_ptr_next;
            cnt_reg          <= cnt_next;
            rem_reg          <= rem_next;
            rd_valid_reg     <= rd_valid_next;
            rd_last_reg      <= rd_last_next;
            result_valid_reg <= result_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (item_valid && item_ready)
        begin
            item_reg <= item;
        end
        result_reg <= result_next;
    end

    // window byte store, one write port and one registered read port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            window_mem[wr_slot] <= item_reg.data_byte;
        end
        if (rd_en)
        begin
            rd_data_reg <= window_mem[emit_ptr_reg];
        end
    end

`ifndef SYNTHESIS
    // held count matches the valid bits between items
    a_held_matches_valid: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_IDLE) |-> ($countones(valid_reg) == int'(held_reg)))
        else $error("held count out of step with valid bits");

    // closed flag is sticky
    a_closed_sticky: assert property (@(posedge clk) disable iff (!rst_n)
        closed_reg |=> closed_reg)
        else $error("closed flag dropped");

    // read stage only holds data while releasing
    a_read_stage_in_emit: assert property (@(posedge clk) disable iff (!rst_n)
        rd_valid_reg |-> (state_reg == S_EMIT))
        else $error("read stage valid outside release");

    // run length never exceeds the window
    a_run_bounded: assert property (@(posedge clk) disable iff (!rst_n)
        (cnt_reg <= CNT_W'(CAPACITY)) && (held_reg <= tbsr_pkg::COUNT_W'(CAPACITY)))
        else $error("run length or held count beyond capacity");

    // nothing released once the stream has closed
    a_no_release_after_close: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_ACCEPT) && closed_reg |=> (state_reg == S_STATUS))
        else $error("item processed after close");
`endif

endmodule

// File: tb/tb_tcp_byte_stream_reassembler.sv
// self-checking testbench for tcp_byte_stream_reassembler: directed and random byte streams
// checked transfer by transfer against a reassembly predictor kept inside the bench
// depends on tbsr_pkg and the top level tcp_byte_stream_reassembler
`timescale 1ns / 1ps

module tb_tcp_byte_stream_reassembler;

    localparam int SLOTS       = 64;
    localparam int ITEMS_TOTAL = 355;
    localparam int CYCLE_LIMIT = 500000;
    localparam int DRAIN_WAIT  = 150;

    logic              clk          = 1'b0;
    logic              rst_n        = 1'b0;
    logic              item_valid   = 1'b0;
    logic              item_ready;
    tbsr_pkg::item_t   item         = '0;
    logic              result_valid;
    logic              result_ready = 1'b0;
    tbsr_pkg::result_t result;

    // stimulus waiting for the driver, and results owed by the block
    tbsr_pkg::item_t   pending_items[$];
    tbsr_pkg::result_t expected_results[$];
    int      items_sent  = 0;
    bit      run_failed  = 1'b0;
    int      cycle_count = 0;

    // reassembly state mirrored from the block
    logic [7:0]  slot_data [SLOTS];
    bit          slot_held [SLOTS];
    logic [63:0] asm_next   = '0;
    logic [63:0] end_pos    = '0;
    bit          end_seen   = 1'b0;
    bit          stream_done = 1'b0;
    int          held_bytes = 0;

    // handshake pacing
    int burst_left  = 0;
    int gap_left    = 0;
    int ready_run   = 0;
    int ready_stall = 0;

    tbsr_pkg::result_t want;

    tcp_byte_stream_reassembler u_top (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_ready   (item_ready),
        .item         (item),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result       (result)
    );

    initial
    begin
        forever #1 clk = ~clk;
    end

    // place one byte or marker, release the contiguous run, queue the results
    task automatic reassemble_item(input tbsr_pkg::item_t it);
        logic [63:0]       offset;
        logic [6:0]        win;
        int                slot;
        logic [7:0]        released[$];
        tbsr_pkg::result_t res;
        if (!stream_done)
        begin
            win = (it.free_space < SLOTS) ? it.free_space : 7'(SLOTS);
            if (it.ends_stream)
            begin
                end_seen = 1'b1;
                end_pos  = it.byte_present ? it.stream_index + 64'd1 : it.stream_index;
            end
            offset = it.stream_index - asm_next;
            if (it.byte_present && it.stream_index >= asm_next && offset < 64'(win))
            begin
                slot = int'(it.stream_index % SLOTS);
                if (!slot_held[slot])
                begin
                    slot_held[slot] = 1'b1;
                    held_bytes++;
                end
                slot_data[slot] = it.data_byte;
            end
            slot = int'(asm_next % SLOTS);
            while (released.size() < SLOTS && slot_held[slot])
            begin
                released.push_back(slot_data[slot]);
                slot_held[slot] = 1'b0;
                if (held_bytes > 0)
                    held_bytes--;
                asm_next = asm_next + 64'd1;
                slot = int'(asm_next % SLOTS);
            end
            if (end_seen && asm_next >= end_pos)
                stream_done = 1'b1;
        end
        res               = '0;
        res.run_last      = 1'b1;
        res.stream_closed = stream_done;
        res.pending_count = 7'(held_bytes);
        if (released.size() == 0)
            expected_results.push_back(res);
        else
            foreach (released[k])
            begin
                res.out_byte  = released[k];
                res.out_valid = 1'b1;
                res.run_last  = (k == released.size() - 1);
                expected_results.push_back(res);
            end
    endtask

    task automatic check_field(string name, logic [7:0] exp_val, logic [7:0] got_val);
        if (got_val !== exp_val)
        begin
            $error("%s mismatch: expected %0d, got %0d", name, exp_val, got_val);
            run_failed = 1'b1;
        end
    endtask

    function automatic logic [63:0] rand64();
        return {$urandom, $urandom};
    endfunction

    task automatic send_item(logic [63:0] idx, logic [7:0] data, bit present, bit ends,
                             logic [6:0] free);
        tbsr_pkg::item_t it;
        it.stream_index = idx;
        it.data_byte    = data;
        it.byte_present = present;
        it.ends_stream  = ends;
        it.free_space   = free;
        pending_items.push_back(it);
        items_sent++;
    endtask

    // hold off until the block has nothing in flight, so the mirrored state is current
    task automatic wait_drained();
        while (pending_items.size() != 0 || item_valid || expected_results.size() != 0)
            @(negedge clk);
    endtask

    // one well-formed run from the next index, shuffled, with strays mixed in
    task automatic send_segment();
        logic [63:0] base;
        logic [6:0]  free;
        int          len;
        int          pick;
        int          tmp;
        int          span;
        int          order[$];
        wait_drained();
        base = asm_next;
        if ($urandom_range(0, 13) == 0)
        begin
            // fill the whole window behind the head, then the head releases it all
            for (int k = SLOTS - 1; k >= 1; k--)
                send_item(base + 64'(k), 8'($urandom), 1'b1, 1'b0, 7'(SLOTS));
            send_item(base, 8'($urandom), 1'b1, 1'b0, 7'($urandom_range(SLOTS, 127)));
            return;
        end
        len = $urandom_range(1, 12);
        for (int k = 0; k < len; k++)
            order.push_back(k);
        for (int k = len - 1; k > 0; k--)
        begin
            pick        = $urandom_range(0, k);
            tmp         = order[k];
            order[k]    = order[pick];
            order[pick] = tmp;
        end
        foreach (order[k])
        begin
            free = ($urandom_range(0, 7) == 0) ? 7'($urandom_range(0, 127))
                                               : 7'($urandom_range(len, 127));
            send_item(base + 64'(order[k]), 8'($urandom), 1'b1, 1'b0, free);
            if ($urandom_range(0, 5) == 0)
            begin
                case ($urandom_range(0, 3))
                    // overlapping byte with fresh data
                    0: send_item(base + 64'($urandom_range(0, len - 1)), 8'($urandom),
                                 1'b1, 1'b0, 7'd127);
                    // byte already assembled
                    1:
                    begin
                        span = (base > 64'd200) ? 200 : int'(base);
                        if (span > 0)
                            send_item(base - 64'($urandom_range(1, span)), 8'($urandom),
                                      1'b1, 1'b0, 7'($urandom));
                        else
                            send_item(rand64(), 8'($urandom), 1'b0, 1'b0, 7'($urandom));
                    end
                    // byte at or past the window end
                    2:
                    begin
                        free = 7'($urandom_range(0, 70));
                        send_item(base + 64'((free > SLOTS) ? SLOTS : free)
                                  + 64'($urandom_range(0, 300)),
                                  8'($urandom), 1'b1, 1'b0, free);
                    end
                    default: send_item(rand64(), 8'($urandom), 1'b0, 1'b0, 7'($urandom));
                endcase
            end
        end
        // a distant end mark that the stream will not reach yet
        if ($urandom_range(0, 9) == 0)
            send_item(base + 64'd100000 + 64'($urandom), 8'($urandom), 1'($urandom),
                      1'b1, 7'($urandom));
    endtask

    // reset, stimulus and end of run
    initial
    begin
        logic [63:0] idx;
        logic [63:0] base;
        bit          ends;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;

        // directed: window extremes, overwrite, drops, end marks
        send_item(64'd0, 8'h00, 1'b0, 1'b0, 7'd0);
        send_item(64'd0, 8'h5A, 1'b1, 1'b0, 7'd0);
        send_item(64'd1, 8'hFF, 1'b1, 1'b0, 7'd64);
        send_item(64'd1, 8'h00, 1'b1, 1'b0, 7'd64);
        send_item(64'd64, 8'h11, 1'b1, 1'b0, 7'd127);
        send_item(64'd63, 8'h22, 1'b1, 1'b0, 7'd65);
        send_item(64'd0, 8'hA5, 1'b1, 1'b0, 7'd2);
        send_item(64'd1, 8'h33, 1'b1, 1'b0, 7'd64);
        send_item('1, 8'hFF, 1'b1, 1'b0, 7'd127);
        send_item('1, 8'h00, 1'b0, 1'b0, 7'd127);
        send_item(64'd1 << 40, 8'h00, 1'b0, 1'b1, 7'd0);
        send_item(64'h8000_0000_0000_0005, 8'h44, 1'b1, 1'b1, 7'd127);
        send_item(64'd2, 8'h80, 1'b1, 1'b0, 7'd1);
        send_item(64'd3, 8'h7F, 1'b1, 1'b0, 7'd127);

        // random: mostly well-formed runs, some loose noise
        while (items_sent < ITEMS_TOTAL)
        begin
            if ($urandom_range(0, 9) < 7)
                send_segment();
            else
                repeat ($urandom_range(1, 6))
                begin
                    idx  = $urandom_range(0, 1) ? rand64()
                                                : asm_next + 64'($urandom_range(0, 80));
                    ends = ($urandom_range(0, 9) == 0);
                    if (ends)
                        idx = {2'b10, idx[61:0]};
                    send_item(idx, 8'($urandom), 1'($urandom), ends, 7'($urandom));
                end
        end

        // close the stream on a final byte, then a few items after the close
        wait_drained();
        base = asm_next;
        send_item(base + 64'd3, 8'($urandom), 1'b1, 1'b1, 7'd64);
        send_item(base + 64'd1, 8'($urandom), 1'b1, 1'b0, 7'd64);
        send_item(base + 64'd2, 8'($urandom), 1'b1, 1'b0, 7'd64);
        send_item(base, 8'($urandom), 1'b1, 1'b0, 7'd127);
        send_item('1, 8'hFF, 1'b1, 1'b1, 7'd127);
        send_item(64'd0, 8'h00, 1'b0, 1'b1, 7'd0);
        send_item(base + 64'd4, 8'h12, 1'b1, 1'b0, 7'd64);

        wait_drained();
        repeat (DRAIN_WAIT) @(negedge clk);
        if (!run_failed)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

    // input driver: bursts of transfers with random gaps
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            item_valid <= 1'b0;
            item       <= '0;
            burst_left <= 0;
            gap_left   <= 0;
        end
        else if (!item_valid || item_ready)
        begin
            if (gap_left != 0 || pending_items.size() == 0)
            begin
                item_valid <= 1'b0;
                if (gap_left != 0)
                    gap_left <= gap_left - 1;
            end
            else
            begin
                item       <= pending_items.pop_front();
                item_valid <= 1'b1;
                if (burst_left <= 1)
                begin
                    burst_left <= $urandom_range(1, 24);
                    gap_left   <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
                end
                else
                begin
                    burst_left <= burst_left - 1;
                end
            end
        end
    end

    // result side: short runs and stalls, the odd long stall, the odd long clear stretch
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            result_ready <= 1'b0;
            ready_run    <= 0;
            ready_stall  <= 0;
        end
        else if (ready_stall != 0)
        begin
            result_ready <= 1'b0;
            ready_stall  <= ready_stall - 1;
        end
        else if (ready_run != 0)
        begin
            result_ready <= 1'b1;
            ready_run    <= ready_run - 1;
        end
        else
        begin
            result_ready <= 1'b1;
            ready_run    <= ($urandom_range(0, 7) == 0) ? 200 : $urandom_range(1, 12);
            ready_stall  <= ($urandom_range(0, 9) == 0) ? $urandom_range(20, 40)
                                                        : $urandom_range(0, 5);
        end
    end

    // monitor: predict on each input transfer, check each result transfer
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (item_valid && item_ready)
                reassemble_item(item);
            if (result_valid && result_ready)
            begin
                if (expected_results.size() == 0)
                begin
                    $error("result transfer with no expectation: byte %0d valid %0d",
                           result.out_byte, result.out_valid);
                    run_failed = 1'b1;
                end
                else
                begin
                    want = expected_results.pop_front();
                    check_field("out_byte", want.out_byte, result.out_byte);
                    check_field("out_valid", 8'(want.out_valid), 8'(result.out_valid));
                    check_field("run_last", 8'(want.run_last), 8'(result.run_last));
                    check_field("stream_closed", 8'(want.stream_closed),
                                8'(result.stream_closed));
                    check_field("pending_count", 8'(want.pending_count),
                                8'(result.pending_count));
                end
            end
        end
    end

    // watchdog
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("== FAIL ==");
            $finish;
        end
    end

endmodule

// File: tcp_byte_stream_reassembler.f
rtl/tbsr_pkg.sv
rtl/tcp_byte_stream_reassembler.sv
tb/tb_tcp_byte_stream_reassembler.sv
